@@ src/nls_pkg.sv @@
// Shared types and constants of the nested loop list sequencer.
package nls_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_PULL  = 2'd2;

  localparam logic [31:0] LOOP_MARK = 32'h8000_0000;
  localparam int unsigned DEPTH_W   = 11;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = 11'd2047;

  typedef struct packed {
    logic wr_entry;
    logic start;
    logic rd_entry;
    logic rd_stack;
    logic advance;
    logic push;
    logic pop;
    logic set_finish;
    logic capture;
    logic emit;
    logic publish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic finished;
    logic endless;
    logic rem_zero;
    logic level_zero;
    logic entry_loop;
    logic skip_loop;
    logic rem_after_zero;
    logic out_busy;
  } ctrl_status_t;

endpackage

@@ src/nls_ram.sv @@
// Generic single write port RAM with a registered read port.
module nls_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/nls_controller.sv @@
// Control state machine that sequences one request at a time through the datapath.
module nls_controller (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           cmd_i,
  input  nls_pkg::ctrl_status_t status_i,
  output nls_pkg::ctrl_cmd_t    ctl_o
);
  import nls_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_ENTRY, S_POP} state_e;

  state_e state_q, state_d;
  logic   accept;

  always_comb begin
    ctl_o      = '0;
    state_d    = state_q;
    in_ready_o = (state_q == S_IDLE) && ((cmd_i != CMD_PULL) || !status_i.out_busy);
    accept     = in_valid_i && in_ready_o;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_WRITE: ctl_o.wr_entry = 1'b1;
            CMD_START: ctl_o.start = 1'b1;
            CMD_PULL: begin
              if (status_i.finished) begin
                ctl_o.capture = 1'b1;
                ctl_o.publish = 1'b1;
              end else if (status_i.endless || !status_i.rem_zero) begin
                ctl_o.rd_entry = 1'b1;
                state_d        = S_ENTRY;
              end else if (status_i.level_zero) begin
                ctl_o.set_finish = 1'b1;
                ctl_o.capture    = 1'b1;
                ctl_o.publish    = 1'b1;
              end else begin
                ctl_o.capture  = 1'b1;
                ctl_o.rd_stack = 1'b1;
                state_d        = S_POP;
              end
            end
            default: ;
          endcase
        end
      end
      S_ENTRY: begin
        ctl_o.capture = 1'b1;
        if (status_i.endless) begin
          ctl_o.emit    = 1'b1;
          ctl_o.advance = 1'b1;
          ctl_o.publish = 1'b1;
          state_d       = S_IDLE;
        end else if (status_i.entry_loop && !status_i.skip_loop) begin
          ctl_o.push    = 1'b1;
          ctl_o.publish = 1'b1;
          state_d       = S_IDLE;
        end else begin
          ctl_o.advance = 1'b1;
          ctl_o.emit    = !status_i.entry_loop;
          if (status_i.rem_after_zero && !status_i.level_zero) begin
            ctl_o.rd_stack = 1'b1;
            state_d        = S_POP;
          end else begin
            ctl_o.set_finish = status_i.rem_after_zero;
            ctl_o.publish    = 1'b1;
            state_d          = S_IDLE;
          end
        end
      end
      S_POP: begin
        ctl_o.pop     = 1'b1;
        ctl_o.publish = 1'b1;
        state_d       = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_entry_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.rd_entry |=> (state_q == S_ENTRY)) else $error("entry state not entered after read");
  a_pop_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.rd_stack |=> ctl_o.pop) else $error("stack read not followed by pop");

endmodule

@@ src/nls_datapath.sv @@
// Datapath with the list store, the context stack, the loop registers and the result register.
module nls_datapath #(
  parameter int unsigned LIST_ENTRIES = 1024,
  parameter int unsigned STACK_LEVELS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nls_pkg::ctrl_cmd_t    ctl_i,
  output nls_pkg::ctrl_status_t status_o,
  input  logic [9:0]            entry_index_i,
  input  logic [31:0]           entry_addr_i,
  input  logic [31:0]           entry_length_i,
  input  logic [31:0]           entry_repeat_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  entry_valid_o,
  output logic [31:0]           out_addr_o,
  output logic [31:0]           out_length_o,
  output logic [31:0]           out_repeat_o,
  output logic                  list_done_o
);
  import nls_pkg::*;

  localparam int unsigned LW    = $clog2(LIST_ENTRIES);
  localparam int unsigned SAW   = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;
  localparam int unsigned LVW   = $clog2(STACK_LEVELS + 1);
  localparam int unsigned CTX_W = 2 * LW + DEPTH_W + 32;
  localparam int unsigned OFF_W = ((LW > DEPTH_W) ? LW : DEPTH_W) + 1;

  function automatic logic [DEPTH_W-1:0] sat_depth(input logic [31:0] d);
    return (d > 32'(DEPTH_MAX)) ? DEPTH_MAX : d[DEPTH_W-1:0];
  endfunction

  logic [LW-1:0]      start_q, start_d, cur_q, cur_d;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [31:0]        rem_q, rem_d;
  logic               endless_q, endless_d;
  logic [LVW-1:0]     level_q, level_d;
  logic               finished_q, finished_d;
  logic               out_valid_q, out_valid_d;
  logic               out_done_q, out_done_d;
  logic               out_ev_q;
  logic [31:0]        out_addr_q, out_length_q, out_repeat_q;

  logic [LW+9:0]      idx_w;
  logic [LW-1:0]      idx_line;
  logic               idx_ok;
  logic [95:0]        store_q;
  logic [31:0]        st_addr, st_length, st_repeat;
  logic [CTX_W-1:0]   stack_q;
  logic [LW-1:0]      pop_start, pop_cur;
  logic [DEPTH_W-1:0] pop_depth;
  logic [31:0]        pop_rem;
  logic [LVW-1:0]     level_m1;
  logic               level_full;
  logic [LW-1:0]      off, adv_cur, nest_start;
  logic [DEPTH_W-1:0] depth_eff;
  logic               body_end;
  logic [31:0]        adv_rem;

  assign idx_w    = (LW + 10)'(entry_index_i);
  assign idx_line = idx_w[LW-1:0];
  assign idx_ok   = idx_w < (LW + 10)'(LIST_ENTRIES);

  assign {st_addr, st_length, st_repeat}          = store_q;
  assign {pop_start, pop_cur, pop_depth, pop_rem} = stack_q;

  assign level_m1   = level_q - 1'b1;
  assign level_full = level_q >= LVW'(STACK_LEVELS);

  assign off       = cur_q - start_q;
  assign depth_eff = (depth_q == '0) ? DEPTH_W'(1) : depth_q;
  assign body_end  = (OFF_W'(off) + OFF_W'(1)) >= OFF_W'(depth_eff);
  assign adv_cur   = body_end ? start_q : cur_q + 1'b1;
  assign adv_rem   = (body_end && !endless_q) ? rem_q - 32'd1 : rem_q;
  assign nest_start = st_addr[LW-1:0] - 1'b1;

  nls_ram #(.WIDTH(96), .DEPTH(LIST_ENTRIES)) u_store (
    .clk_i   (clk_i),
    .we_i    (ctl_i.wr_entry && idx_ok),
    .waddr_i (idx_line),
    .wdata_i ({entry_addr_i, entry_length_i, entry_repeat_i}),
    .re_i    (ctl_i.rd_entry),
    .raddr_i (cur_q),
    .rdata_o (store_q)
  );

  nls_ram #(.WIDTH(CTX_W), .DEPTH(STACK_LEVELS)) u_stack (
    .clk_i   (clk_i),
    .we_i    (ctl_i.push),
    .waddr_i (level_q[SAW-1:0]),
    .wdata_i ({start_q, adv_cur, depth_q, adv_rem}),
    .re_i    (ctl_i.rd_stack),
    .raddr_i (level_m1[SAW-1:0]),
    .rdata_o (stack_q)
  );

  always_comb begin
    start_d     = start_q;
    cur_d       = cur_q;
    depth_d     = depth_q;
    rem_d       = rem_q;
    endless_d   = endless_q;
    level_d     = level_q;
    finished_d  = finished_q;
    out_valid_d = out_valid_q;
    out_done_d  = out_done_q;
    if (ctl_i.start) begin
      start_d    = idx_line;
      cur_d      = idx_line;
      depth_d    = sat_depth(entry_length_i);
      rem_d      = entry_repeat_i;
      endless_d  = (entry_repeat_i == '0);
      level_d    = '0;
      finished_d = 1'b0;
    end
    if (ctl_i.advance) begin
      cur_d = adv_cur;
      rem_d = adv_rem;
    end
    if (ctl_i.push) begin
      level_d = level_q + 1'b1;
      start_d = nest_start;
      cur_d   = nest_start;
      depth_d = sat_depth(st_length);
      rem_d   = st_repeat;
    end
    if (ctl_i.pop) begin
      level_d = level_m1;
      start_d = pop_start;
      cur_d   = pop_cur;
      depth_d = pop_depth;
      rem_d   = pop_rem;
    end
    if (ctl_i.set_finish) begin
      finished_d = 1'b1;
    end
    if (ctl_i.publish) begin
      out_valid_d = 1'b1;
      out_done_d  = finished_q || ctl_i.set_finish;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      cur_q       <= '0;
      depth_q     <= '0;
      rem_q       <= '0;
      endless_q   <= 1'b0;
      level_q     <= '0;
      finished_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_done_q  <= 1'b0;
    end else begin
      start_q     <= start_d;
      cur_q       <= cur_d;
      depth_q     <= depth_d;
      rem_q       <= rem_d;
      endless_q   <= endless_d;
      level_q     <= level_d;
      finished_q  <= finished_d;
      out_valid_q <= out_valid_d;
      out_done_q  <= out_done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.capture) begin
      out_ev_q     <= ctl_i.emit;
      out_addr_q   <= ctl_i.emit ? st_addr : '0;
      out_length_q <= ctl_i.emit ? st_length : '0;
      out_repeat_q <= ctl_i.emit ? st_repeat : '0;
    end
  end

  assign status_o.finished       = finished_q;
  assign status_o.endless        = endless_q;
  assign status_o.rem_zero       = (rem_q == '0);
  assign status_o.level_zero     = (level_q == '0);
  assign status_o.entry_loop     = (st_addr & LOOP_MARK) != '0;
  assign status_o.skip_loop      = (st_repeat == '0) || level_full;
  assign status_o.rem_after_zero = (adv_rem == '0);
  assign status_o.out_busy       = out_valid_q;

  assign out_valid_o   = out_valid_q;
  assign entry_valid_o = out_ev_q;
  assign out_addr_o    = out_addr_q;
  assign out_length_o  = out_length_q;
  assign out_repeat_o  = out_repeat_q;
  assign list_done_o   = out_done_q;

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> !level_full) else $error("context pushed onto a full stack");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |-> (level_q != '0)) else $error("context popped from an empty stack");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.publish |-> !out_valid_q) else $error("result published over a pending result");
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LVW'(STACK_LEVELS)) else $error("stack level beyond its depth");

endmodule

@@ src/nested_loop_list_sequencer.sv @@
// Top level of the nested loop list sequencer: controller, datapath and the result port.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_ready_o   cmd_i, entry_index_i, entry_addr_i,
//                                                 entry_length_i, entry_repeat_i
//   out      output     out_valid_o / out_ready_i entry_valid_o, out_addr_o, out_length_o,
//                                                 out_repeat_o, list_done_o
//
// Write and start requests finish in the idle state; so does a pull that finds the list
// done or ends it. Other pulls go to the entry state after a list store read, to the pop
// state after a stack read, or through both in that order: RAM read ports are registered.
// Reset clears the loop registers and the stack level; the list store and the stack are
// not cleared. Write and start requests are taken while a result waits; a pull waits until
// the pending result is taken. LIST_ENTRIES must be a power of two.
module nested_loop_list_sequencer #(
  parameter int unsigned LIST_ENTRIES = 1024,
  parameter int unsigned STACK_LEVELS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [9:0]  entry_index_i,
  input  logic [31:0] entry_addr_i,
  input  logic [31:0] entry_length_i,
  input  logic [31:0] entry_repeat_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        entry_valid_o,
  output logic [31:0] out_addr_o,
  output logic [31:0] out_length_o,
  output logic [31:0] out_repeat_o,
  output logic        list_done_o
);
  import nls_pkg::*;

  ctrl_cmd_t    ctl;
  ctrl_status_t status;

  nls_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .status_i   (status),
    .ctl_o      (ctl)
  );

  nls_datapath #(
    .LIST_ENTRIES (LIST_ENTRIES),
    .STACK_LEVELS (STACK_LEVELS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (ctl),
    .status_o       (status),
    .entry_index_i  (entry_index_i),
    .entry_addr_i   (entry_addr_i),
    .entry_length_i (entry_length_i),
    .entry_repeat_i (entry_repeat_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .entry_valid_o  (entry_valid_o),
    .out_addr_o     (out_addr_o),
    .out_length_o   (out_length_o),
    .out_repeat_o   (out_repeat_o),
    .list_done_o    (list_done_o)
  );

endmodule

@@ tb/sv/nls_checker.sv @@
`timescale 1ns / 1ps
// Checker that mirrors the nested loop list sequencer and compares every result it gives.
module nls_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  cmd_i,
  input  logic [9:0]  entry_index_i,
  input  logic [31:0] entry_addr_i,
  input  logic [31:0] entry_length_i,
  input  logic [31:0] entry_repeat_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        entry_valid_i,
  input  logic [31:0] out_addr_i,
  input  logic [31:0] out_length_i,
  input  logic [31:0] out_repeat_i,
  input  logic        list_done_i,
  output int          fail_count_o,
  output int          pending_o
);
  import nls_pkg::*;

  localparam int unsigned LINES  = 1024;
  localparam int unsigned LEVELS = 8;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] len;
    logic [31:0] rep;
  } list_entry_t;

  typedef struct packed {
    logic [9:0]         start;
    logic [9:0]         cur;
    logic [DEPTH_W-1:0] depth;
    logic [31:0]        remaining;
  } loop_ctx_t;

  typedef struct packed {
    logic        entry_valid;
    logic [31:0] addr;
    logic [31:0] len;
    logic [31:0] rep;
    logic        done;
  } step_result_t;

  list_entry_t  store [LINES];
  loop_ctx_t    ctx_stack [LEVELS];
  loop_ctx_t    active = '0;
  logic         endless = 1'b0;
  logic         finished = 1'b0;
  int unsigned  level = 0;
  step_result_t pending_steps [$];

  function automatic logic [DEPTH_W-1:0] clip_depth(logic [31:0] d);
    return (d > 32'(DEPTH_MAX)) ? DEPTH_MAX : d[DEPTH_W-1:0];
  endfunction

  // Moves past the current line; at the body end it rewinds and a finite count drops.
  function automatic void step_line();
    logic [9:0]  off;
    logic [11:0] span;
    off  = active.cur - active.start;
    span = (active.depth == '0) ? 12'd1 : {1'b0, active.depth};
    if ({2'b00, off} + 12'd1 >= span) begin
      if (!endless) begin
        active.remaining = active.remaining - 32'd1;
      end
      active.cur = active.start;
    end else begin
      active.cur = active.cur + 10'd1;
    end
  endfunction

  function automatic void close_spent();
    if (active.remaining != '0) begin
      return;
    end
    if (level == 0) begin
      finished = 1'b1;
    end else begin
      level  = level - 1;
      active = ctx_stack[level];
    end
  endfunction

  function automatic step_result_t pull_step();
    list_entry_t  line_entry;
    logic [9:0]   nested_line;
    step_result_t res;
    res        = '0;
    line_entry = store[active.cur];
    if (finished) begin
    end else if (endless) begin
      res.entry_valid = 1'b1;
      res.addr        = line_entry.addr;
      res.len         = line_entry.len;
      res.rep         = line_entry.rep;
      step_line();
    end else if (active.remaining == '0) begin
      close_spent();
    end else if ((line_entry.addr & LOOP_MARK) != '0) begin
      if (line_entry.rep == '0 || level >= LEVELS) begin
        step_line();
        close_spent();
      end else begin
        nested_line = line_entry.addr[9:0];
        step_line();
        ctx_stack[level] = active;
        level            = level + 1;
        active.start     = nested_line - 10'd1;
        active.cur       = active.start;
        active.depth     = clip_depth(line_entry.len);
        active.remaining = line_entry.rep;
      end
    end else begin
      res.entry_valid = 1'b1;
      res.addr        = line_entry.addr;
      res.len         = line_entry.len;
      res.rep         = line_entry.rep;
      step_line();
      close_spent();
    end
    res.done = finished;
    return res;
  endfunction

  function automatic void predict_request(logic [1:0] cmd, logic [9:0] idx, logic [31:0] a,
                                          logic [31:0] l, logic [31:0] r);
    case (cmd)
      CMD_WRITE: begin
        store[idx] = '{addr: a, len: l, rep: r};
      end
      CMD_START: begin
        active.start     = idx;
        active.cur       = idx;
        active.depth     = clip_depth(l);
        active.remaining = r;
        endless          = (r == '0);
        level            = 0;
        finished         = 1'b0;
      end
      CMD_PULL: begin
        pending_steps.push_back(pull_step());
      end
      default: begin
      end
    endcase
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin : monitor
    step_result_t want;
    if (!rst_ni) begin
      active   = '0;
      endless  = 1'b0;
      finished = 1'b0;
      level    = 0;
      pending_steps.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_steps.size() == 0) begin
          $error("result with no pull request waiting: entry_valid %0b, out_addr %0h",
                 entry_valid_i, out_addr_i);
          fail_count_o++;
        end else begin
          want = pending_steps.pop_front();
          check_field("entry_valid", 32'(want.entry_valid), 32'(entry_valid_i));
          check_field("out_addr", want.addr, out_addr_i);
          check_field("out_length", want.len, out_length_i);
          check_field("out_repeat", want.rep, out_repeat_i);
          check_field("list_done", 32'(want.done), 32'(list_done_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_request(cmd_i, entry_index_i, entry_addr_i, entry_length_i, entry_repeat_i);
      end
    end
    pending_o = pending_steps.size();
  end

endmodule

@@ tb/sv/tb_nested_loop_list_sequencer.sv @@
`timescale 1ns / 1ps
// Testbench top for the nested loop list sequencer: requests, idling, watchdog and verdict.
module tb_nested_loop_list_sequencer;
  import nls_pkg::*;

  localparam int unsigned LINES          = 1024;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int          RANDOM_ITEMS   = 600;
  localparam int          CALM_ITEMS     = 60;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 8;
  localparam int          CHAIN_LEVELS   = 11;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i          = CMD_WRITE;
  logic [9:0]  entry_index_i  = '0;
  logic [31:0] entry_addr_i   = '0;
  logic [31:0] entry_length_i = '0;
  logic [31:0] entry_repeat_i = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic        entry_valid_o;
  logic [31:0] out_addr_o;
  logic [31:0] out_length_o;
  logic [31:0] out_repeat_o;
  logic        list_done_o;

  int fail_count;
  int pending;
  int sent          = 0;
  int stall_cycles  = 0;
  bit idle_on       = 1'b1;
  bit hold_off_req  = 1'b0;
  bit held          = 1'b0;

  nested_loop_list_sequencer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .entry_index_i  (entry_index_i),
    .entry_addr_i   (entry_addr_i),
    .entry_length_i (entry_length_i),
    .entry_repeat_i (entry_repeat_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .entry_valid_o  (entry_valid_o),
    .out_addr_o     (out_addr_o),
    .out_length_o   (out_length_o),
    .out_repeat_o   (out_repeat_o),
    .list_done_o    (list_done_o)
  );

  nls_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .cmd_i          (cmd_i),
    .entry_index_i  (entry_index_i),
    .entry_addr_i   (entry_addr_i),
    .entry_length_i (entry_length_i),
    .entry_repeat_i (entry_repeat_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .entry_valid_i  (entry_valid_o),
    .out_addr_i     (out_addr_o),
    .out_length_i   (out_length_o),
    .out_repeat_i   (out_repeat_o),
    .list_done_i    (list_done_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  always begin : receiver
    @(posedge clk_i);
    if (hold_off_req) begin
      hold_off_req = 1'b0;
      out_ready_i <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk_i);
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(0, 17)) @(posedge clk_i);
    end else begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(0, 15)) @(posedge clk_i);
    end
  end

  task automatic send_request(logic [1:0] cmd, logic [9:0] idx, logic [31:0] a,
                              logic [31:0] l, logic [31:0] r);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    cmd_i          <= cmd;
    entry_index_i  <= idx;
    entry_addr_i   <= a;
    entry_length_i <= l;
    entry_repeat_i <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (cmd != CMD_UNUSED) begin
      sent++;
    end
  endtask

  task automatic send_pulls(int unsigned count);
    repeat (count) send_request(CMD_PULL, 10'($urandom), $urandom, $urandom, $urandom);
  endtask

  // Region 0 is the top loop body; a region only opens loops on regions with a higher number,
  // so nested bodies are written before the entries that call them.
  task automatic build_program(bit chain);
    logic [9:0]  bases [CHAIN_LEVELS];
    int unsigned depths [CHAIN_LEVELS];
    int          regions;
    int unsigned callee;
    logic [31:0] a;
    logic [31:0] l;
    logic [31:0] r;
    regions = chain ? CHAIN_LEVELS : $urandom_range(1, 4);
    for (int k = 0; k < regions; k++) begin
      bases[k]  = 10'($urandom);
      depths[k] = chain ? 1 : $urandom_range(1, 5);
    end
    for (int k = regions - 1; k >= 0; k--) begin
      for (int unsigned i = 0; i < depths[k]; i++) begin
        if (k + 1 < regions && (chain || $urandom_range(0, 2) == 0)) begin
          callee = chain ? k + 1 : $urandom_range(k + 1, regions - 1);
          a      = $urandom;
          a[31]  = 1'b1;
          a[9:0] = bases[callee] + 10'd1;
          l      = (depths[callee] == 1 && $urandom_range(0, 1) == 0) ? 0 : depths[callee];
          r      = chain ? 1 : $urandom_range(0, 3);
          send_request(CMD_WRITE, bases[k] + 10'(i), a, l, r);
        end else begin
          send_request(CMD_WRITE, bases[k] + 10'(i), $urandom & ~LOOP_MARK, $urandom,
                       $urandom);
        end
      end
    end
    r = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, chain ? 2 : 3);
    send_request(CMD_START, bases[0], $urandom, 32'(depths[0]), r);
    send_pulls(chain ? 40 : $urandom_range(10, 50));
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_pulls(1);
    send_request(CMD_UNUSED, '1, '1, '1, '1);
    for (int i = 0; i < LINES; i++) begin
      send_request(CMD_WRITE, 10'(i), $urandom, $urandom, $urandom);
    end

    // An endless top loop wraps past the last line and emits loop entries as they are.
    send_request(CMD_WRITE, 10'd1023, '1, '1, '1);
    send_request(CMD_WRITE, 10'd0, '0, '0, '0);
    send_request(CMD_START, 10'd1023, '0, 32'd2, 32'd0);
    send_pulls(3);

    // A nested loop at one-based line zero, then a zero-repeat loop entry at the body end.
    send_request(CMD_WRITE, 10'd1023, 32'h7fff_ffff, '0, '1);
    send_request(CMD_WRITE, 10'd5, LOOP_MARK, 32'd1, 32'd2);
    send_request(CMD_WRITE, 10'd6, LOOP_MARK | 32'd100, 32'd3, 32'd0);
    send_request(CMD_START, 10'd5, '0, 32'd2, 32'd1);
    send_pulls(5);
    send_request(CMD_START, 10'd0, '0, 32'd0, 32'd1);
    send_pulls(2);
    send_request(CMD_START, 10'd5, '0, 32'd1, 32'd1);
    send_pulls(4);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_on = (sent < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 4) != 0);
      if (!held && sent >= 200) begin
        hold_off_req = 1'b1;
        held         = 1'b1;
      end
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_request(2'($urandom_range(0, 3)), 10'($urandom), $urandom, $urandom, $urandom);
        end
      end
      build_program($urandom_range(0, 6) == 0);
    end
    idle_on = 1'b0;
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/nls_pkg.sv
src/nls_ram.sv
src/nls_controller.sv
src/nls_datapath.sv
src/nested_loop_list_sequencer.sv
tb/sv/nls_checker.sv
tb/sv/tb_nested_loop_list_sequencer.sv
